// ===== rtl/core/oal_pkg.sv =====
`default_nettype none

package oal_pkg;

	// Wide enough for any list index or count at the largest supported depth.
	localparam int CELL_IDX_W = 7;

	typedef enum logic [2:0] {
		MODE_INS_FRONT = 3'd0,
		MODE_INS_BACK  = 3'd1,
		MODE_INS_POS   = 3'd2,
		MODE_RM_FRONT  = 3'd3,
		MODE_RM_BACK   = 3'd4,
		MODE_RM_VALUE  = 3'd5,
		MODE_RM_POS    = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_BAD_POS   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE_AT,
		CELL_REMOVE_HIT
	} cell_op_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] item_value;
		logic [5:0]         position;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] element_count;
	} res_t;

	// Broadcast from the controller to every cell of the row.
	typedef struct packed {
		logic                  capture;
		cell_op_t              op;
		logic [CELL_IDX_W-1:0] idx;
		logic [CELL_IDX_W-1:0] count;
		logic [31:0]           value;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/oal_cell.sv =====
`default_nettype none

module oal_cell #(
	parameter int INDEX = 0
) (
	input  wire logic              clk,
	input  wire oal_pkg::cell_ctl_t ctl,
	input  wire logic [31:0]       from_left,
	input  wire logic [31:0]       from_right,
	input  wire logic              hit_in,
	output logic                   hit_out,
	output logic [31:0]            elem
);

	localparam int IW = oal_pkg::CELL_IDX_W;
	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic [31:0] elem_q;
	logic        eq_q;
	logic        hit_here;

	assign elem = elem_q;

	// Only live entries may match; stale contents past the count are ignored.
	assign hit_here = eq_q && (MY_IDX < ctl.count);
	assign hit_out  = hit_in || hit_here;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			eq_q <= (elem_q == ctl.value);
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			oal_pkg::CELL_INSERT: begin
				if (MY_IDX == ctl.idx) begin
					elem_q <= ctl.value;
				end else if (MY_IDX > ctl.idx) begin
					elem_q <= from_left;
				end
			end
			oal_pkg::CELL_REMOVE_AT: begin
				if (MY_IDX >= ctl.idx) begin
					elem_q <= from_right;
				end
			end
			oal_pkg::CELL_REMOVE_HIT: begin
				// The first match and everything after it close the gap.
				if (hit_out) begin
					elem_q <= from_right;
				end
			end
			default: begin
				elem_q <= elem_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/ordered_array_list_unit.sv =====
// Ordered list of up to DEPTH signed 32-bit values held in a row of cells, one
// element per cell, with insert, remove and remove-by-value requests that shift
// the later elements by one place. Each request is handled in two steps: in the
// cycle it is accepted every cell compares its element against the request
// value, and in a later cycle in which no result is held back by res_stall the
// row shifts and the result is written to the output register. A new request
// is accepted only after the last one has shifted; req_stall is high only
// while a request waits for its shift cycle, and a waiting result delays that
// cycle. Cells at or beyond the count hold stale data that is never reported.
// No clearing pass is needed after reset.
`default_nettype none

module ordered_array_list_unit #(
	parameter int DEPTH = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire oal_pkg::req_t  req,
	output logic                res_valid,
	input  wire logic           res_stall,
	output oal_pkg::res_t       res
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IW    = oal_pkg::CELL_IDX_W;

	oal_pkg::cell_ctl_t ctl;
	oal_pkg::req_t      cmd_q;
	oal_pkg::res_t      res_q;
	logic               cmd_valid_q;
	logic               res_valid_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_next;
	logic [2:0]         status_next;
	oal_pkg::cell_op_t  op_next;
	logic [IW-1:0]      idx_next;
	logic [IW-1:0]      pos_w;
	logic [IW-1:0]      cnt_w;
	logic               accept;
	logic               exec;
	logic               full;
	logic               empty;
	logic               found;
	logic [31:0]        elem [DEPTH];
	logic [DEPTH:0]     hit_chain;

	assign req_stall = cmd_valid_q;
	assign accept    = req_valid && !cmd_valid_q;
	assign exec      = cmd_valid_q && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign pos_w = IW'(cmd_q.position);
	assign cnt_w = IW'(count_q);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign found = hit_chain[DEPTH];
	assign hit_chain[0] = 1'b0;

	always_comb begin
		status_next = oal_pkg::ST_OK;
		count_next  = count_q;
		op_next     = oal_pkg::CELL_HOLD;
		idx_next    = '0;
		case (cmd_q.mode)
			oal_pkg::MODE_INS_FRONT, oal_pkg::MODE_INS_BACK, oal_pkg::MODE_INS_POS: begin
				if (full) begin
					status_next = oal_pkg::ST_FULL;
				end else begin
					op_next    = oal_pkg::CELL_INSERT;
					count_next = count_q + CNT_W'(1);
					if (cmd_q.mode == oal_pkg::MODE_INS_FRONT) begin
						idx_next = '0;
					end else if (cmd_q.mode == oal_pkg::MODE_INS_BACK || pos_w > cnt_w) begin
						idx_next = cnt_w;
					end else begin
						idx_next = pos_w;
					end
				end
			end
			oal_pkg::MODE_RM_FRONT: begin
				if (empty) begin
					status_next = oal_pkg::ST_EMPTY;
				end else begin
					op_next    = oal_pkg::CELL_REMOVE_AT;
					count_next = count_q - CNT_W'(1);
				end
			end
			oal_pkg::MODE_RM_BACK: begin
				if (empty) begin
					status_next = oal_pkg::ST_EMPTY;
				end else begin
					count_next = count_q - CNT_W'(1);
				end
			end
			oal_pkg::MODE_RM_VALUE: begin
				// Without a match no cell sees a hit, so the row stays put.
				if (empty) begin
					status_next = oal_pkg::ST_EMPTY;
				end else begin
					op_next = oal_pkg::CELL_REMOVE_HIT;
					if (found) begin
						count_next = count_q - CNT_W'(1);
					end else begin
						status_next = oal_pkg::ST_NOT_FOUND;
					end
				end
			end
			oal_pkg::MODE_RM_POS: begin
				if (empty) begin
					status_next = oal_pkg::ST_EMPTY;
				end else if (pos_w >= cnt_w) begin
					status_next = oal_pkg::ST_BAD_POS;
				end else begin
					op_next    = oal_pkg::CELL_REMOVE_AT;
					idx_next   = pos_w;
					count_next = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_next = oal_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		ctl.capture = accept;
		ctl.op      = exec ? op_next : oal_pkg::CELL_HOLD;
		ctl.idx     = idx_next;
		ctl.count   = cnt_w;
		ctl.value   = accept ? req.item_value : cmd_q.item_value;
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [31:0] left_w;
		logic [31:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = ctl.value;
		end else begin : g_inner_l
			assign left_w = elem[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_w = elem[g];
		end else begin : g_inner_r
			assign right_w = elem[g+1];
		end

		oal_cell #(
			.INDEX(g)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.from_left (left_w),
			.from_right(right_w),
			.hit_in    (hit_chain[g]),
			.hit_out   (hit_chain[g+1]),
			.elem      (elem[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				cmd_valid_q <= 1'b1;
			end else if (exec) begin
				cmd_valid_q <= 1'b0;
			end
			if (exec) begin
				res_valid_q <= 1'b1;
				count_q     <= count_next;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req;
		end
		if (exec) begin
			res_q.status        <= status_next;
			res_q.element_count <= 5'(count_next);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count exceeds the list depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		!exec |=> $stable(count_q))
		else $error("element count changed without an executed request");

	assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> res_valid && res.element_count == 5'(count_q))
		else $error("result count does not match the list count");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == oal_pkg::ST_FULL |-> res.element_count == 5'(DEPTH))
		else $error("full status reported on a list that is not full");

endmodule

`default_nettype wire
